FILE: rtl/core/assert_macros.svh
// Assertion shorthands used by the checker file of this block.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ERS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ERS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ers_pkg.sv
`default_nettype none

package ers_pkg;

    // Fixed field widths.
    localparam int CFG_W     = 6;
    localparam int POS_W     = 5;
    localparam int REG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_STEPS  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PULSES = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROT    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] STEPS_RST  = 6'd16;
    localparam logic [CFG_W-1:0] PULSES_RST = 6'd4;
    localparam logic [CFG_W-1:0] ROT_RST    = 6'd0;

    localparam int DEF_MAX_STEPS = 32;

    // Which quotient or remainder the shared divider is working on.
    typedef enum logic [1:0] {
        DIV_PER,
        DIV_NSK,
        DIV_SKL,
        DIV_ROT
    } div_op_t;

    typedef enum logic [3:0] {
        ST_PER_GO,
        ST_PER_WAIT,
        ST_NSK_GO,
        ST_NSK_WAIT,
        ST_SKL_GO,
        ST_SKL_WAIT,
        ST_ROT_GO,
        ST_ROT_WAIT,
        ST_FILL_INIT,
        ST_FILL,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic    div_start;
        logic    div_latch;
        div_op_t div_op;
        logic    fill_init;
        logic    fill_step;
        logic    run;
    } ers_cmd_t;

    typedef struct packed {
        logic cfg_hit;
        logic div_done;
        logic fill_last;
    } ers_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/ers_if.sv
`default_nettype none

interface ers_in_if ();
    logic valid;
    logic ready;
    logic clock_level;

    modport source (output valid, output clock_level, input ready);
    modport sink (input valid, input clock_level, output ready);
endinterface

interface ers_out_if import ers_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             pulse_out;
    logic             pulse_out_inverted;
    logic             no_advance;
    logic [POS_W-1:0] step_position;

    modport source (
        output valid, output pulse_out, output pulse_out_inverted,
        output no_advance, output step_position, input ready
    );
    modport sink (
        input valid, input pulse_out, input pulse_out_inverted,
        input no_advance, input step_position, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/ers_ram.sv
`default_nettype none

module ers_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ers_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ers_div #(
    parameter int W = 6
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic      [W-1:0] quotient,
    output logic      [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W:0]       rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;

    logic [W:0] shifted;
    logic [W:0] diff;
    logic       fits;

    assign shifted = {rem_reg[W-1:0], quo_reg[W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff : shifted;
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/ers_ctrl.sv
`default_nettype none

module ers_ctrl import ers_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ers_stat_t stat,
    output ers_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PER_GO;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Any write to a listed register starts the build over.
    always_comb
    begin
        state_next = state_reg;
        if (stat.cfg_hit)
        begin
            state_next = ST_PER_GO;
        end
        else
        begin
            case (state_reg)
                ST_PER_GO:    state_next = ST_PER_WAIT;
                ST_PER_WAIT:  state_next = stat.div_done ? ST_NSK_GO : ST_PER_WAIT;
                ST_NSK_GO:    state_next = ST_NSK_WAIT;
                ST_NSK_WAIT:  state_next = stat.div_done ? ST_SKL_GO : ST_NSK_WAIT;
                ST_SKL_GO:    state_next = ST_SKL_WAIT;
                ST_SKL_WAIT:  state_next = stat.div_done ? ST_ROT_GO : ST_SKL_WAIT;
                ST_ROT_GO:    state_next = ST_ROT_WAIT;
                ST_ROT_WAIT:  state_next = stat.div_done ? ST_FILL_INIT : ST_ROT_WAIT;
                ST_FILL_INIT: state_next = ST_FILL;
                ST_FILL:      state_next = stat.fill_last ? ST_RUN : ST_FILL;
                ST_RUN:       state_next = ST_RUN;
                default:      state_next = ST_PER_GO;
            endcase
        end
    end

    always_comb
    begin
        cmd = '0;
        cmd.div_op = DIV_PER;
        case (state_reg)
            ST_PER_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_PER;
            end
            ST_PER_WAIT:
            begin
                cmd.div_latch = 1'b1;
                cmd.div_op    = DIV_PER;
            end
            ST_NSK_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_NSK;
            end
            ST_NSK_WAIT:
            begin
                cmd.div_latch = 1'b1;
                cmd.div_op    = DIV_NSK;
            end
            ST_SKL_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_SKL;
            end
            ST_SKL_WAIT:
            begin
                cmd.div_latch = 1'b1;
                cmd.div_op    = DIV_SKL;
            end
            ST_ROT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_ROT;
            end
            ST_ROT_WAIT:
            begin
                cmd.div_latch = 1'b1;
                cmd.div_op    = DIV_ROT;
            end
            ST_FILL_INIT: cmd.fill_init = 1'b1;
            ST_FILL:      cmd.fill_step = 1'b1;
            ST_RUN:       cmd.run = 1'b1;
            default:      cmd.run = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/ers_dp.sv
`default_nettype none

module ers_dp import ers_pkg::*; #(
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire ers_cmd_t             cmd,
    output ers_stat_t                 stat,
    ers_in_if.sink                    in_ch,
    ers_out_if.source                 out_ch
);

    localparam int CW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int NW = $clog2(MAX_STEPS + 1);
    localparam int DW = (NW > CFG_W) ? NW : CFG_W;
    localparam int SW = DW + 2;

    // Configuration registers.
    logic [CFG_W-1:0] step_count_reg;
    logic [CFG_W-1:0] pulse_count_reg;
    logic [CFG_W-1:0] rotation_reg;
    logic             cfg_hit;

    assign cfg_hit = cfg_write && (cfg_index == REG_STEPS || cfg_index == REG_PULSES
                                   || cfg_index == REG_ROT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg  <= STEPS_RST;
            pulse_count_reg <= PULSES_RST;
            rotation_reg    <= ROT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_STEPS:  step_count_reg  <= cfg_data;
                REG_PULSES: pulse_count_reg <= cfg_data;
                REG_ROT:    rotation_reg    <= cfg_data;
                default:    step_count_reg  <= step_count_reg;
            endcase
        end
    end

    // Effective step and pulse counts, and the roles of marks and gaps.
    logic [DW-1:0] n_eff;
    logic [DW-1:0] pulses;
    logic [DW-1:0] hits;
    logic [DW-1:0] gaps0;
    logic [DW-1:0] marks;
    logic [DW-1:0] gaps;
    logic          swapped;
    logic          all_on;
    logic          all_off;

    always_comb
    begin
        if (step_count_reg == '0)
        begin
            n_eff = DW'(1);
        end
        else if (DW'(step_count_reg) > DW'(MAX_STEPS))
        begin
            n_eff = DW'(MAX_STEPS);
        end
        else
        begin
            n_eff = DW'(step_count_reg);
        end
    end

    assign pulses  = DW'(pulse_count_reg);
    assign hits    = (pulses > n_eff) ? n_eff : pulses;
    assign gaps0   = n_eff - hits;
    assign swapped = hits > gaps0;
    assign marks   = swapped ? gaps0 : hits;
    assign gaps    = swapped ? hits : gaps0;
    assign all_on  = hits == n_eff;
    assign all_off = hits == '0;

    // Shared divider and the spacing values it produces.
    logic [DW-1:0] dvd;
    logic [DW-1:0] dvs;
    logic [DW-1:0] dvs_nz;
    logic          div_done;
    logic [DW-1:0] div_quo;
    logic [DW-1:0] div_rem;

    logic [DW-1:0] per_reg;
    logic [DW-1:0] remb_reg;
    logic [DW-1:0] noskip_reg;
    logic [DW-1:0] sklb_reg;
    logic [CW-1:0] rot_reg;

    always_comb
    begin
        case (cmd.div_op)
            DIV_PER:
            begin
                dvd = gaps;
                dvs = marks;
            end
            DIV_NSK:
            begin
                dvd = marks;
                dvs = remb_reg;
            end
            DIV_SKL:
            begin
                dvd = marks - remb_reg;
                dvs = noskip_reg;
            end
            default:
            begin
                dvd = DW'(rotation_reg);
                dvs = n_eff;
            end
        endcase
    end

    // A zero divisor only shows up where the result is not used.
    assign dvs_nz = (dvs == '0) ? DW'(1) : dvs;

    ers_div #(
        .W (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dvs_nz),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.div_latch && div_done)
        begin
            case (cmd.div_op)
                DIV_PER:
                begin
                    per_reg  <= div_quo;
                    remb_reg <= div_rem;
                end
                DIV_NSK:  noskip_reg <= (remb_reg == '0) ? '0 : div_quo;
                DIV_SKL:  sklb_reg   <= (noskip_reg == '0) ? '0 : div_quo;
                default:  rot_reg    <= CW'(div_rem);
            endcase
        end
    end

    // Pattern fill: one step per cycle, written at its rotated place.
    logic [DW-1:0] run_reg;
    logic [DW-1:0] run_next;
    logic [DW-1:0] remc_reg;
    logic [DW-1:0] remc_next;
    logic [SW-1:0] skipper_reg;
    logic [SW-1:0] skipper_next;
    logic [SW-1:0] skl_reg;
    logic [SW-1:0] skl_next;
    logic [CW-1:0] fpos_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] last_idx;
    logic          skl_pos;
    logic          raw_bit;
    logic          wr_bit;

    assign last_idx = CW'(n_eff - DW'(1));
    assign skl_pos  = !skl_reg[SW-1] && (skl_reg != '0);

    always_comb
    begin
        run_next     = run_reg;
        remc_next    = remc_reg;
        skipper_next = skipper_reg;
        skl_next     = skl_reg;
        if (run_reg == '0)
        begin
            raw_bit  = !swapped;
            run_next = per_reg;
            if (remc_reg != '0 && skipper_reg == '0)
            begin
                run_next     = per_reg + DW'(1);
                remc_next    = remc_reg - DW'(1);
                skipper_next = skl_pos ? SW'(noskip_reg) : '0;
                skl_next     = skl_reg - SW'(1);
            end
            else
            begin
                skipper_next = skipper_reg - SW'(1);
            end
        end
        else
        begin
            raw_bit  = swapped;
            run_next = run_reg - DW'(1);
        end
    end

    assign wr_bit = all_on ? 1'b1 : (all_off ? 1'b0 : raw_bit);

    always_ff @(posedge clk)
    begin
        if (cmd.fill_init)
        begin
            run_reg     <= '0;
            remc_reg    <= remb_reg;
            skipper_reg <= '0;
            skl_reg     <= SW'(sklb_reg);
            fpos_reg    <= rot_reg;
            idx_reg     <= '0;
        end
        else if (cmd.fill_step)
        begin
            run_reg     <= run_next;
            remc_reg    <= remc_next;
            skipper_reg <= skipper_next;
            skl_reg     <= skl_next;
            fpos_reg    <= (fpos_reg == last_idx) ? '0 : fpos_reg + CW'(1);
            idx_reg     <= idx_reg + CW'(1);
        end
    end

    // Playback.
    logic          prev_clk_reg;
    logic [CW-1:0] cursor_reg;
    logic [CW-1:0] prev_cur_reg;
    logic [CW-1:0] cur_new;
    logic          fall;
    logic          accept;
    logic          out_free;
    logic          ram_rdata;

    logic             pend_valid_reg;
    logic             pend_noadv_reg;
    logic [POS_W-1:0] pend_pos_reg;
    logic             out_valid_reg;
    logic             out_pulse_reg;
    logic             out_noadv_reg;
    logic [POS_W-1:0] out_pos_reg;

    assign fall     = prev_clk_reg && !in_ch.clock_level;
    assign cur_new  = fall ? ((cursor_reg == last_idx) ? '0 : cursor_reg + CW'(1))
                           : cursor_reg;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = cmd.run && (!pend_valid_reg || out_free);
    assign accept   = in_ch.valid && in_ch.ready;

    ers_ram #(
        .WIDTH (1),
        .DEPTH (MAX_STEPS)
    ) u_pattern (
        .clk   (clk),
        .we    (cmd.fill_step),
        .waddr (fpos_reg),
        .wdata (wr_bit),
        .re    (accept),
        .raddr (cur_new),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clk_reg   <= 1'b0;
            cursor_reg     <= '0;
            prev_cur_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_hit)
            begin
                cursor_reg <= '0;
            end
            else if (accept)
            begin
                cursor_reg <= cur_new;
            end
            if (accept)
            begin
                prev_clk_reg <= in_ch.clock_level;
                prev_cur_reg <= cur_new;
            end
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_valid_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_noadv_reg <= prev_cur_reg == cur_new;
            pend_pos_reg   <= POS_W'(cur_new);
        end
        if (pend_valid_reg && out_free)
        begin
            out_pulse_reg <= ram_rdata;
            out_noadv_reg <= pend_noadv_reg;
            out_pos_reg   <= pend_pos_reg;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.pulse_out          = out_pulse_reg;
    assign out_ch.pulse_out_inverted = !out_pulse_reg;
    assign out_ch.no_advance         = out_noadv_reg;
    assign out_ch.step_position      = out_pos_reg;

    assign stat.cfg_hit   = cfg_hit;
    assign stat.div_done  = div_done;
    assign stat.fill_last = idx_reg == last_idx;

endmodule

`default_nettype wire

FILE: rtl/core/euclidean_rhythm_sequencer.sv
`default_nettype none

// Euclidean rhythm sequencer. After reset, and again after every write to the step
// count, pulse count or rotation register, the block builds a pattern of step_count
// bits (0 counts as 1, values above MAX_STEPS as MAX_STEPS) holding pulse_count
// pulses (clamped to the step count), spaced with a per-pulse run, a remainder and a
// skip interval, and rotated right by rotation modulo the step count. The build runs
// four divisions on one shared bit-serial divider and then writes one step per cycle
// into the pattern memory; the divider is 6 bits wide at the default MAX_STEPS of 32.
// While it runs, in_ch.ready is low; configuration writes are still taken at any time
// and simply restart the build. Once the pattern is in place, the block takes one item
// per cycle while the output path is not stalled. Each item carries a clock level; a
// one-to-zero transition against the previous item advances the step cursor, wrapping
// at the step count. Its result, which passes through a pending register and then the
// output register, carries the pattern bit at the cursor, its complement, a flag that
// the cursor matches the one of the previous item, and the cursor itself. The rate is
// set by the single read port of the pattern memory, which is read once per item. A
// configuration write puts the cursor back at step 0 but keeps the remembered clock
// level and cursor, so the next item compares step 0 with the cursor of the item
// before. A write to an index beyond the three registers is ignored.

module euclidean_rhythm_sequencer import ers_pkg::*; #(
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    ers_in_if.sink                    in_ch,
    ers_out_if.source                 out_ch
);

    // The controller sequences the build (divisions, then the fill sweep) and
    // then holds the block in playback; it sees only status from the datapath.
    ers_cmd_t  cmd;
    ers_stat_t stat;

    ers_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // The datapath holds the configuration, the divider, the pattern memory and
    // the playback pipeline with its output register.
    ers_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

FILE: rtl/core/ers_checker.sv
`default_nettype none

`include "assert_macros.svh"

module ers_checker import ers_pkg::*; (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cfg_write,
    input wire logic [REG_IDX_W-1:0] cfg_index,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic                 pulse_out,
    input wire logic                 pulse_out_inverted,
    input wire logic                 no_advance,
    input wire logic [POS_W-1:0]     step_position
);

    logic cfg_listed;

    assign cfg_listed = cfg_write && (cfg_index == REG_STEPS || cfg_index == REG_PULSES
                                      || cfg_index == REG_ROT);

    // A write to a listed register always starts a rebuild, after which in_ready is low and items stop.
    `ERS_ASSERT_NXT(a_cfg_blocks_items, cfg_listed, !in_ready, "item taken during rebuild")

    // The two pulse outputs are always complementary.
    `ERS_ASSERT_IMP(a_pulse_pair, out_valid, pulse_out_inverted != pulse_out, "pulse pair equal")

    // A stalled result holds its contents.
    `ERS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pulse_out) && $stable(no_advance) && $stable(step_position), "stalled result changed")

endmodule

bind euclidean_rhythm_sequencer ers_checker u_ers_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .in_ready           (in_ch.ready),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .pulse_out          (out_ch.pulse_out),
    .pulse_out_inverted (out_ch.pulse_out_inverted),
    .no_advance         (out_ch.no_advance),
    .step_position      (out_ch.step_position)
);

`default_nettype wire
